// ----- hw/rtl/prct_pkg.sv -----
// ============================================================================
// prct_pkg : shared constants for the planet ring collision test
// Field widths, register map indices, reset values and the plane threshold.
// ============================================================================
`default_nettype none

package prct_pkg;

    // Field widths
    localparam int COORD_W = 32;  // Q23.8 world coordinates
    localparam int QUAT_W  = 16;  // Q1.14 quaternion parts
    localparam int RING_W  = 16;  // Q2.14 ring radii
    localparam int SIZE_W  = 31;  // Q23.8 planet radius

    // Configuration register map (index = paddr / 4)
    localparam int          ADDR_W    = 5;
    localparam logic [2:0]  REG_CX    = 3'd0;
    localparam logic [2:0]  REG_CY    = 3'd1;
    localparam logic [2:0]  REG_CZ    = 3'd2;
    localparam logic [2:0]  REG_OW    = 3'd3;
    localparam logic [2:0]  REG_OX    = 3'd4;
    localparam logic [2:0]  REG_OY    = 3'd5;
    localparam logic [2:0]  REG_OZ    = 3'd6;
    localparam logic [2:0]  REG_SIZE  = 3'd7;

    // Reset values
    localparam logic signed [QUAT_W-1:0] OW_RST   = 16'sd16384;
    localparam logic [SIZE_W-1:0]        SIZE_RST = 31'd256;

    // Plane proximity threshold, Q23.8, and the same scaled to Q.36
    localparam longint                DAMAGE_DISTANCE = 25600;
    localparam logic signed [68:0]    NEAR_LIM        = 69'(DAMAGE_DISTANCE) << 28;
    localparam logic signed [68:0]    NEAR_LIM_NEG    = -NEAR_LIM;

endpackage

`default_nettype wire

// ----- hw/rtl/planet_ring_collision_test.sv -----
// The result reaches o_m_tdata through stages 1 to 5 and then the output register.
// Throughput: one object per cycle unless the output stalls; six register stages set the latency.
// A stalled output freezes the whole pipeline and drops o_s_tready.
// Reset (synchronous, active low) clears all valid bits and restores the
// configuration registers: centre 0, orientation identity, planet size 256.
// ============================================================================
// planet_ring_collision_test : point in ring annulus and near ring plane
// Squared centre distance is checked against the scaled ring band, and the
// projection onto the rotated ring normal against the damage distance.
// ============================================================================
`default_nettype none

module planet_ring_collision_test
    import prct_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Object stream
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    // [31:0] obj_x, [63:32] obj_y, [95:64] obj_z,
    // [111:96] ring_inner, [127:112] ring_outer
    input  wire logic [127:0]        i_s_tdata,
    // Result stream
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    // [0] hit, [7:1] zero
    output logic [7:0]               o_m_tdata,
    // Configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] r_cx, r_cy, r_cz;
    logic signed [QUAT_W-1:0]  r_ow, r_ox, r_oy, r_oz;
    logic [SIZE_W-1:0]         r_size;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Write the addressed register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx   <= '0;
            r_cy   <= '0;
            r_cz   <= '0;
            r_ow   <= OW_RST;
            r_ox   <= '0;
            r_oy   <= '0;
            r_oz   <= '0;
            r_size <= SIZE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_CX:   r_cx   <= pwdata;
                REG_CY:   r_cy   <= pwdata;
                REG_CZ:   r_cz   <= pwdata;
                REG_OW:   r_ow   <= pwdata[QUAT_W-1:0];
                REG_OX:   r_ox   <= pwdata[QUAT_W-1:0];
                REG_OY:   r_oy   <= pwdata[QUAT_W-1:0];
                REG_OZ:   r_oz   <= pwdata[QUAT_W-1:0];
                REG_SIZE: r_size <= pwdata[SIZE_W-1:0];
                default:  ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (paddr[4:2])
            REG_CX:   prdata = r_cx;
            REG_CY:   prdata = r_cy;
            REG_CZ:   prdata = r_cz;
            REG_OW:   prdata = {16'd0, r_ow};
            REG_OX:   prdata = {16'd0, r_ox};
            REG_OY:   prdata = {16'd0, r_oy};
            REG_OZ:   prdata = {16'd0, r_oz};
            REG_SIZE: prdata = {1'b0, r_size};
            default:  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances together unless the output
    // register holds a result that is not being taken
    // ------------------------------------------------------------------
    logic       pipe_en;
    logic [4:0] r_vld;       // valid of stages 1..5
    logic       r_m_tvalid;
    logic       r_hit;

    assign pipe_en    = !r_m_tvalid || i_m_tready;
    assign o_s_tready = pipe_en;
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {7'd0, r_hit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_m_tvalid <= 1'b0;
        end else if (pipe_en) begin
            r_vld      <= {r_vld[3:0], i_s_tvalid};
            r_m_tvalid <= r_vld[4];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: offsets from the centre, ring radii times planet size,
    // quaternion products
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] obj_x, obj_y, obj_z;
    logic [RING_W-1:0]         ring_inner, ring_outer;

    assign obj_x      = i_s_tdata[31:0];
    assign obj_y      = i_s_tdata[63:32];
    assign obj_z      = i_s_tdata[95:64];
    assign ring_inner = i_s_tdata[111:96];
    assign ring_outer = i_s_tdata[127:112];

    logic signed [32:0] r1_d [3];
    logic [46:0]        r1_in_ps, r1_out_ps;
    logic signed [31:0] r1_ww, r1_xx, r1_yy, r1_zz, r1_xz, r1_wy, r1_yz, r1_wx;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r1_d[0]   <= 33'(obj_x) - 33'(r_cx);
            r1_d[1]   <= 33'(obj_y) - 33'(r_cy);
            r1_d[2]   <= 33'(obj_z) - 33'(r_cz);
            r1_in_ps  <= 47'(ring_inner) * 47'(r_size);
            r1_out_ps <= 47'(ring_outer) * 47'(r_size);
            r1_ww     <= 32'(r_ow) * 32'(r_ow);
            r1_xx     <= 32'(r_ox) * 32'(r_ox);
            r1_yy     <= 32'(r_oy) * 32'(r_oy);
            r1_zz     <= 32'(r_oz) * 32'(r_oz);
            r1_xz     <= 32'(r_ox) * 32'(r_oz);
            r1_wy     <= 32'(r_ow) * 32'(r_oy);
            r1_yz     <= 32'(r_oy) * 32'(r_oz);
            r1_wx     <= 32'(r_ow) * 32'(r_ox);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squared offsets, partial products of the squared limits,
    // ring plane normal
    // ------------------------------------------------------------------
    logic signed [65:0] sq [3];
    logic signed [32:0] nxy_x, nxy_y;
    logic [64:0]        r2_dsq [3];
    logic [63:0]        r2_in_ll, r2_out_ll;
    logic [46:0]        r2_in_lh, r2_out_lh;
    logic [29:0]        r2_in_hh, r2_out_hh;
    logic signed [33:0] r2_n [3];
    logic signed [32:0] r2_d [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            sq[a] = 66'(r1_d[a]) * 66'(r1_d[a]);
        end
        nxy_x = 33'(r1_xz) + 33'(r1_wy);
        nxy_y = 33'(r1_yz) - 33'(r1_wx);
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            for (int a = 0; a < 3; a++) begin
                r2_dsq[a] <= sq[a][64:0];
                r2_d[a]   <= r1_d[a];
            end
            r2_in_ll  <= 64'(r1_in_ps[31:0]) * 64'(r1_in_ps[31:0]);
            r2_in_lh  <= 47'(r1_in_ps[31:0]) * 47'(r1_in_ps[46:32]);
            r2_in_hh  <= 30'(r1_in_ps[46:32]) * 30'(r1_in_ps[46:32]);
            r2_out_ll <= 64'(r1_out_ps[31:0]) * 64'(r1_out_ps[31:0]);
            r2_out_lh <= 47'(r1_out_ps[31:0]) * 47'(r1_out_ps[46:32]);
            r2_out_hh <= 30'(r1_out_ps[46:32]) * 30'(r1_out_ps[46:32]);
            r2_n[0]   <= {nxy_x, 1'b0};
            r2_n[1]   <= {nxy_y, 1'b0};
            r2_n[2]   <= 34'(r1_ww) - 34'(r1_xx) - 34'(r1_yy) + 34'(r1_zz);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squared distance, squared limits, split dot products
    // ------------------------------------------------------------------
    logic [65:0]        r3_d2;
    logic [93:0]        r3_lim_in, r3_lim_out;
    logic signed [49:0] r3_ph [3];
    logic signed [51:0] r3_pl [3];

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r3_d2      <= 66'(r2_dsq[0]) + 66'(r2_dsq[1]) + 66'(r2_dsq[2]);
            r3_lim_in  <= 94'(r2_in_ll) + (94'(r2_in_lh) << 33) + (94'(r2_in_hh) << 64);
            r3_lim_out <= 94'(r2_out_ll) + (94'(r2_out_lh) << 33)
                          + (94'(r2_out_hh) << 64);
            // Split each offset into a signed upper and unsigned lower half
            for (int a = 0; a < 3; a++) begin
                r3_ph[a] <= 50'(r2_n[a]) * 50'($signed(r2_d[a][32:17]));
                r3_pl[a] <= 52'(r2_n[a]) * 52'($signed({1'b0, r2_d[a][16:0]}));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: band compares, per-axis dot terms
    // ------------------------------------------------------------------
    logic [93:0]        d2_q44;
    logic               r4_band;
    logic signed [67:0] r4_pa [3];

    assign d2_q44 = {r3_d2, 28'd0};

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r4_band <= (d2_q44 >= r3_lim_in) && (r3_lim_out >= d2_q44);
            for (int a = 0; a < 3; a++) begin
                r4_pa[a] <= (68'(r3_ph[a]) <<< 17) + 68'(r3_pl[a]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: dot product sum
    // ------------------------------------------------------------------
    logic signed [68:0] r5_dot;
    logic               r5_band;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r5_dot  <= 69'(r4_pa[0]) + 69'(r4_pa[1]) + 69'(r4_pa[2]);
            r5_band <= r4_band;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: plane proximity and final flag
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_hit <= r5_band && (r5_dot < NEAR_LIM) && (r5_dot > NEAR_LIM_NEG);
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_only_on_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_m_tvalid && !i_m_tready))
        else $error("input stalled while output free");

    a_accept_enters_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_vld[0])
        else $error("accepted transaction missing from stage 1");

    a_last_stage_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pipe_en && r_vld[4]) |=> r_m_tvalid)
        else $error("stage 5 transaction lost before output");

    a_stall_freezes_valids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pipe_en |=> $stable(r_vld))
        else $error("pipeline valids moved during stall");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// ============================================================================
// tb_top : self-checking bench for planet_ring_collision_test
// Streams object positions through the block under random source and sink
// stalls. Planet settings are reloaded over APB between phases. Every
// accepted object is scored by an independent model of the band and plane
// tests, and each hit flag that comes back is checked in order.
// ============================================================================
module tb_top
    import prct_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 95;

    // One object transaction, packed as on i_s_tdata (last field lowest)
    typedef struct packed {
        logic [15:0] outer;
        logic [15:0] inner;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } t_obj;

    typedef struct {
        logic [31:0] cx, cy, cz;
        logic [15:0] ow, ox, oy, oz;
        logic [30:0] size;
    } t_planet_cfg;

    typedef enum int {CFG_ALIGNED, CFG_EXTREME, CFG_RANDOM} t_cfg_kind;

    // Ring hit scoreboard: planet settings, predictor and pending hit flags
    class ring_hit_board;
        logic signed [31:0] cx, cy, cz;
        logic signed [15:0] ow, ox, oy, oz;
        logic [30:0]        planet_size;
        bit                 hit_q[$];
        int                 errors;

        function new();
            cx = '0;
            cy = '0;
            cz = '0;
            ow = OW_RST;
            ox = '0;
            oy = '0;
            oz = '0;
            planet_size = SIZE_RST;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_CX:   cx = v;
                REG_CY:   cy = v;
                REG_CZ:   cz = v;
                REG_OW:   ow = v[15:0];
                REG_OX:   ox = v[15:0];
                REG_OY:   oy = v[15:0];
                REG_OZ:   oz = v[15:0];
                REG_SIZE: planet_size = v[30:0];
                default:  ;
            endcase
        endfunction

        // Band test on squared distances, plane test on the rotated normal
        function bit ring_hit(t_obj o);
            logic signed [127:0] dx, dy, dz, nx, ny, nz, dot;
            logic [127:0]        d2, span, lim_in, lim_out, dot_mag, near_lim;
            bit                  band, near;
            dx = $signed(o.x) - cx;
            dy = $signed(o.y) - cy;
            dz = $signed(o.z) - cz;
            d2 = dx * dx + dy * dy + dz * dz;
            d2 = d2 << 28;
            span = o.inner * planet_size;
            lim_in = span * span;
            span = o.outer * planet_size;
            lim_out = span * span;
            band = (d2 >= lim_in) && (d2 <= lim_out);
            // n = q (0,0,1) q*, left unnormalised
            nx = 2 * (ox * oz + ow * oy);
            ny = 2 * (oy * oz - ow * ox);
            nz = ow * ow - ox * ox - oy * oy + oz * oz;
            dot = nx * dx + ny * dy + nz * dz;
            dot_mag = dot[127] ? -dot : dot;
            near_lim = 128'(DAMAGE_DISTANCE) << 28;
            near = dot_mag < near_lim;
            return band && near;
        endfunction

        function void note_object(t_obj o);
            hit_q.push_back(ring_hit(o));
        endfunction

        function void check_result(logic [7:0] tdata);
            bit want;
            if (hit_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: tdata %h with nothing pending", tdata);
            end else begin
                want = hit_q.pop_front();
                if (tdata !== {7'd0, want}) begin
                    errors++;
                    if (errors <= 10)
                        $display("hit mismatch: expected %0d got tdata %h", want, tdata);
                end
            end
        endfunction

        function int pending();
            return hit_q.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [127:0]      i_s_tdata;
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [7:0]        o_m_tdata;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    ring_hit_board board;
    int            tx_pct;
    int            rx_pct;
    int            cycles;

    planet_ring_collision_test i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Abort on a hung run
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Check every result transaction against the oldest pending hit flag
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_m_tvalid === 1'b1 && i_m_tready === 1'b1)
            board.check_result(o_m_tdata);
    end

    // Sink: drop tready in random bursts
    initial begin : sink_ready
        int stall;
        stall = 0;
        i_m_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                stall--;
                i_m_tready <= 1'b0;
            end else if (rx_pct != 0 && $urandom_range(0, 99) < rx_pct) begin
                stall = $urandom_range(0, 13);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    function automatic t_obj mk_obj(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                    logic [15:0] ri, logic [15:0] ro);
        t_obj o;
        o.x = x;
        o.y = y;
        o.z = z;
        o.inner = ri;
        o.outer = ro;
        return o;
    endfunction

    function automatic t_obj noise_obj();
        return mk_obj($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom));
    endfunction

    // Place an object near the ring: radius in the band, jittered across its edges, offset across
    // the plane straddling the damage distance along the normal's axis (a random axis if skewed)
    function automatic t_obj ring_obj(t_planet_cfg c, int axis);
        t_obj        o;
        logic [15:0] swap;
        longint      r_lo, r_hi, r, off;
        logic [31:0] comp[3];
        int          a;
        o.inner = 16'($urandom);
        o.outer = 16'($urandom);
        if (o.inner > o.outer && $urandom_range(0, 9) != 0) begin
            swap = o.inner;
            o.inner = o.outer;
            o.outer = swap;
        end
        r_lo = (longint'(o.inner) * longint'(c.size)) >>> 14;
        r_hi = (longint'(o.outer) * longint'(c.size)) >>> 14;
        r = r_lo + ((r_hi - r_lo) * $urandom_range(0, 1024)) / 1024
            + $urandom_range(0, 4) - 2;
        off = longint'($urandom_range(0, 60000)) - 30000;
        a = (axis < 3) ? axis : $urandom_range(0, 2);
        comp[a] = 32'(off);
        comp[(a + 1) % 3] = $urandom_range(0, 1) ? 32'(r) : 32'(-r);
        comp[(a + 2) % 3] = 32'($urandom_range(0, 128)) - 32'd64;
        o.x = c.cx + comp[0];
        o.y = c.cy + comp[1];
        o.z = c.cz + comp[2];
        return o;
    endfunction

    function automatic logic [31:0] extreme32();
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] extreme16();
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0;
            default: return 16'h4000;
        endcase
    endfunction

    // Build planet settings; axis names the normal's axis, or 3 if skewed
    function automatic t_planet_cfg make_planet(t_cfg_kind kind, output int axis);
        t_planet_cfg c;
        axis = 3;
        case (kind)
            CFG_ALIGNED: begin
                c.cx = 32'($urandom_range(0, 1 << 29)) - 32'(1 << 28);
                c.cy = 32'($urandom_range(0, 1 << 29)) - 32'(1 << 28);
                c.cz = 32'($urandom_range(0, 1 << 29)) - 32'(1 << 28);
                c.size = 31'($urandom_range(1 << 14, 1 << 20));
                c.ox = '0;
                c.oy = '0;
                c.oz = '0;
                axis = 2;
                // 11585 is about 16384 / sqrt(2): quarter turns
                case ($urandom_range(0, 6))
                    0: c.ow = 16'd16384;
                    1: begin
                        c.ow = 16'd11585;
                        c.oz = 16'd11585;
                    end
                    2: begin
                        c.ow = '0;
                        c.ox = 16'd16384;
                    end
                    3: begin
                        c.ow = 16'd11585;
                        c.ox = 16'd11585;
                        axis = 1;
                    end
                    4: begin
                        c.ow = 16'd11585;
                        c.oy = 16'd11585;
                        axis = 0;
                    end
                    5: c.ow = 16'd8192;
                    default: begin
                        c.ow = '0;
                        c.oz = 16'h8000;
                    end
                endcase
            end
            CFG_EXTREME: begin
                c.cx = extreme32();
                c.cy = extreme32();
                c.cz = extreme32();
                c.ow = extreme16();
                c.ox = extreme16();
                c.oy = extreme16();
                c.oz = extreme16();
                case ($urandom_range(0, 3))
                    0:       c.size = '0;
                    1:       c.size = 31'd1;
                    2:       c.size = 31'h7fff_ffff;
                    default: c.size = SIZE_RST;
                endcase
            end
            default: begin
                c.cx = $urandom;
                c.cy = $urandom;
                c.cz = $urandom;
                c.ow = 16'($urandom);
                c.ox = 16'($urandom);
                c.oy = 16'($urandom);
                c.oz = 16'($urandom);
                c.size = 31'($urandom);
            end
        endcase
        return c;
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 8;
            2:       return 20;
            default: return 40;
        endcase
    endfunction

    // Setup then access phase; psel is released by apb_release
    task automatic apb_write(logic [2:0] idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        board.set_reg(idx, v);
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Unused upper bits get junk to show they are ignored
    task automatic load_planet(t_planet_cfg c);
        apb_write(REG_CX, c.cx);
        apb_write(REG_CY, c.cy);
        apb_write(REG_CZ, c.cz);
        apb_write(REG_OW, {16'($urandom), c.ow});
        apb_write(REG_OX, {16'($urandom), c.ox});
        apb_write(REG_OY, {16'($urandom), c.oy});
        apb_write(REG_OZ, {16'($urandom), c.oz});
        apb_write(REG_SIZE, {1'($urandom), c.size});
        apb_release();
    endtask

    // Optional idle burst, then hold the transaction until it is taken
    task automatic send_obj(t_obj o);
        if (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= o;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        board.note_object(o);
    endtask

    // Stop sending, wait for every pending result, then idle past the pipe depth
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_planet_cfg pc;
        int          axis;
        t_cfg_kind   kind;
        t_obj        o;
        board = new();
        tx_pct = 10;
        rx_pct = 10;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: unit planet at origin, identity orientation
        send_obj(mk_obj(32'd256, 32'd0, 32'd0, 16'd16384, 16'd16384));
        send_obj(mk_obj(32'd257, 32'd0, 32'd0, 16'd16384, 16'd16384));
        send_obj(mk_obj(32'd0, -32'sd255, 32'd0, 16'd16384, 16'd16384));
        send_obj(mk_obj(32'd0, 32'd0, 32'd0, 16'd0, 16'd0));
        // inner radius above outer: empty band
        send_obj(mk_obj(32'd256, 32'd0, 32'd0, 16'd20000, 16'd10000));
        send_obj(mk_obj(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'd0, 16'hffff));
        send_obj(mk_obj(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'hffff, 16'hffff));
        send_obj(mk_obj(32'h8000_0000, 32'h7fff_ffff, 32'd0, 16'hffff, 16'd0));
        drain();

        // Large planet: probe the plane threshold and the outer bound
        pc.cx = 32'd1000;
        pc.cy = -32'sd2000;
        pc.cz = 32'd3000;
        pc.ow = 16'd16384;
        pc.ox = '0;
        pc.oy = '0;
        pc.oz = '0;
        pc.size = 31'd65536;
        load_planet(pc);
        send_obj(mk_obj(pc.cx + 32'd131072, pc.cy, pc.cz + 32'd25599, 16'd16384, 16'hffff));
        send_obj(mk_obj(pc.cx + 32'd131072, pc.cy, pc.cz + 32'd25600, 16'd16384, 16'hffff));
        send_obj(mk_obj(pc.cx + 32'd131072, pc.cy, pc.cz - 32'd25599, 16'd16384, 16'hffff));
        send_obj(mk_obj(pc.cx + 32'd131072, pc.cy, pc.cz - 32'd25600, 16'd16384, 16'hffff));
        send_obj(mk_obj(pc.cx + 32'd262140, pc.cy, pc.cz, 16'd16384, 16'hffff));
        send_obj(mk_obj(pc.cx + 32'd262141, pc.cy, pc.cz, 16'd16384, 16'hffff));
        drain();

        // Zero planet size: band holds only at the centre
        pc.cx = 32'h7fff_ffff;
        pc.cy = 32'h8000_0000;
        pc.cz = 32'd0;
        pc.ow = 16'h8000;
        pc.ox = 16'h7fff;
        pc.oy = 16'h8000;
        pc.oz = 16'h7fff;
        pc.size = '0;
        load_planet(pc);
        send_obj(mk_obj(pc.cx, pc.cy, pc.cz, 16'hffff, 16'hffff));
        send_obj(mk_obj(pc.cx, pc.cy + 32'd1, pc.cz, 16'hffff, 16'hffff));
        send_obj(mk_obj(pc.cx, pc.cy, pc.cz, 16'd0, 16'd0));
        drain();

        // Random phases; the last one runs without any stalls
        for (int p = 0; p < PHASES; p++) begin
            if (p == 1 || p == 5)
                kind = CFG_EXTREME;
            else if (p == 3 || p == 7)
                kind = CFG_RANDOM;
            else
                kind = CFG_ALIGNED;
            pc = make_planet(kind, axis);
            load_planet(pc);
            tx_pct = (p == PHASES - 1) ? 0 : pick_pct();
            rx_pct = (p == PHASES - 1) ? 0 : pick_pct();
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 2 && k == PHASE_ITEMS / 2)
                    drain();
                if ($urandom_range(0, 99) < 70)
                    o = ring_obj(pc, axis);
                else
                    o = noise_obj();
                send_obj(o);
            end
            drain();
        end

        if (board.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/prct_pkg.sv
hw/rtl/planet_ring_collision_test.sv
test/tb_top.sv
